>>> design/crp_pkg.sv
// crp_pkg: shared types and constants of the circle raster painter.
// No dependencies; every other design file but crp_ram refers to it by scoped names.
`default_nettype none

package crp_pkg;

    localparam int MAX_SIDE_DEF = 256;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int FIX_W      = 20;
    localparam int CHAR_W     = 8;
    localparam int COORD_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_SIDE_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SQ_W       = 2 * FIX_W;

    localparam logic [FIX_W-1:0] ONE_FIX = FIX_W'(256);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RADIUS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHAPE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

    // shape characters
    localparam logic [CHAR_W-1:0] SHAPE_FILLED = 8'h43;  // 'C'
    localparam logic [CHAR_W-1:0] SHAPE_RIM    = 8'h63;  // 'c'

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [FIX_W-1:0] center_x;
        logic signed [FIX_W-1:0] center_y;
        logic signed [FIX_W-1:0] radius;
        logic [CHAR_W-1:0]       shape_char;
        logic [CHAR_W-1:0]       paint_char;
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      column;
    } t_cmd_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   pixel;
    } t_rsp_word;

    // circle setup handed to the distance test pipeline
    typedef struct packed {
        logic signed [FIX_W-1:0] cx;
        logic signed [FIX_W-1:0] cy;
        logic [SQ_W-1:0]         r2;
        logic [SQ_W-1:0]         rim2;
        logic                    rim_all;
        logic                    filled;
    } t_circle;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_DRAW,
        ST_DRAIN,
        ST_READ,
        ST_RDATA,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

>>> design/crp_cmd_if.sv
// crp_cmd_if: valid/ready channel carrying one command word.
// Depends on crp_pkg for the payload type.
`default_nettype none

interface crp_cmd_if;
    logic                  valid;
    logic                  ready;
    crp_pkg::t_cmd_word    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/crp_rsp_if.sv
// crp_rsp_if: valid/ready channel carrying one result word.
// Depends on crp_pkg for the payload type.
`default_nettype none

interface crp_rsp_if;
    logic                  valid;
    logic                  ready;
    crp_pkg::t_rsp_word    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/crp_ram.sv
// crp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module crp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/crp_dist.sv
// crp_dist: pipelined squared-distance test, one pixel per cycle, three stages.
// Depends on crp_pkg (t_circle).
`default_nettype none

module crp_dist #(
    parameter int MAX_SIDE = crp_pkg::MAX_SIDE_DEF,
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1),
    localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_issue,
    input  wire logic [SIDE_W-1:0]    i_col,
    input  wire logic [SIDE_W-1:0]    i_row,
    input  wire logic [AW-1:0]        i_addr,
    input  wire crp_pkg::t_circle     i_circ,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic                      o_busy
);

    localparam int POS_W = SIDE_W + 9;  // col*256 with a sign bit
    localparam int DX_W  = ((POS_W > crp_pkg::FIX_W) ? POS_W : crp_pkg::FIX_W) + 1;
    localparam int P_W   = 2 * DX_W;
    localparam int D_W   = P_W + 1;

    logic signed [POS_W-1:0] col_fix, row_fix;
    logic signed [DX_W-1:0]  dx, dy;
    logic signed [P_W-1:0]   dx_ext, dy_ext, dx_sq, dy_sq;
    logic [D_W-1:0]          r2_ext, rim2_ext;
    logic                    in_disk, on_rim;

    logic               r_p1_valid, r_p2_valid;
    logic [P_W-1:0]     r_p1_dx2, r_p1_dy2;
    logic [AW-1:0]      r_p1_addr, r_p2_addr;
    logic [D_W-1:0]     r_p2_d2;

    always_comb begin
        col_fix = $signed({1'b0, i_col, 8'h00});
        row_fix = $signed({1'b0, i_row, 8'h00});
        dx      = DX_W'(col_fix) - DX_W'(i_circ.cx);
        dy      = DX_W'(row_fix) - DX_W'(i_circ.cy);
        dx_ext  = P_W'(dx);
        dy_ext  = P_W'(dy);
        dx_sq   = dx_ext * dx_ext;
        dy_sq   = dy_ext * dy_ext;
    end

    // stage 1: squares, stage 2: sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_issue;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_dx2  <= dx_sq;
        r_p1_dy2  <= dy_sq;
        r_p1_addr <= i_addr;
        r_p2_d2   <= D_W'(r_p1_dx2) + D_W'(r_p1_dy2);
        r_p2_addr <= r_p1_addr;
    end

    // stage 3: compare against r^2 and (r-1)^2
    always_comb begin
        r2_ext   = D_W'(i_circ.r2);
        rim2_ext = D_W'(i_circ.rim2);
        in_disk  = (r_p2_d2 <= r2_ext);
        on_rim   = i_circ.filled || i_circ.rim_all || (r_p2_d2 > rim2_ext);
    end

    assign o_we    = r_p2_valid && in_disk && on_rim;
    assign o_waddr = r_p2_addr;
    assign o_busy  = r_p1_valid || r_p2_valid;

endmodule

`default_nettype wire

>>> design/circle_raster_painter.sv
// circle_raster_painter: character canvas with clear, circle draw and pixel read.
// Depends on crp_pkg, crp_cmd_if, crp_rsp_if, crp_ram and crp_dist.
//
// Use: commands arrive on i_cmd (valid/ready), one result word per command
// leaves on o_rsp (valid/ready). Config (width, height, background char) is
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only
// while the block is idle, and the block itself does not enforce this. The
// canvas lives in a MAX_SIDE*MAX_SIDE x 8 RAM; one command is worked on at a
// time, and i_cmd.ready is high only while the block is idle. Work per command:
//   clear : one RAM write per cycle over the whole store
//   draw  : setup multiply, one pixel per cycle through the three-stage
//           distance pipeline, drain
//   read  : one registered RAM read
//   error or unused kind : straight to the result state
// The result word sits in an output register; the next command is accepted
// while it waits. If the receiver stalls, a finished command holds until the
// output register frees up. Reset clears control state and the config
// registers (256, 256, 0x20); canvas content is undefined until a clear.
`default_nettype none

module circle_raster_painter #(
    parameter int MAX_SIDE = crp_pkg::MAX_SIDE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    crp_cmd_if.sink                               i_cmd,
    crp_rsp_if.source                             o_rsp,
    input  wire logic                             i_cfg_we,
    input  wire logic [crp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [crp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (SIDE_W > crp_pkg::CFG_SIDE_W) ? SIDE_W : crp_pkg::CFG_SIDE_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    function automatic logic [SIDE_W-1:0] clamp_side(
        input logic [crp_pkg::CFG_SIDE_W-1:0] v
    );
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0) begin
            return SIDE_W'(1);
        end else if (ext > CMP_W'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(ext);
    endfunction

    crp_pkg::t_state r_state, n_state;

    logic [crp_pkg::CFG_SIDE_W-1:0] r_cfg_w, r_cfg_h;
    logic [crp_pkg::CHAR_W-1:0]     r_cfg_bg;
    logic [SIDE_W-1:0]              w_cl, h_cl;

    crp_pkg::t_circle               r_circ;
    logic signed [crp_pkg::FIX_W-1:0] r_radius;
    logic signed [crp_pkg::FIX_W-1:0] rm1;
    logic [crp_pkg::CHAR_W-1:0]     r_paint;
    logic [SIDE_W-1:0]              r_col, r_row;
    logic [AW-1:0]                  r_row_base;
    logic [AW-1:0]                  r_clr_addr;
    logic [AW-1:0]                  r_rd_addr;
    logic                           r_rd_ok;
    crp_pkg::t_rsp_word             r_res;
    logic                           r_out_valid;
    crp_pkg::t_rsp_word             r_out_data;

    logic                           accept, bad_radius, bad_shape;
    logic                           clr_we, rd_en, issue, out_load;
    logic                           last_col, last_row;
    logic                           dist_we, dist_busy;
    logic [AW-1:0]                  dist_waddr;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [crp_pkg::CHAR_W-1:0]     ram_wdata, ram_rdata;

    assign w_cl = clamp_side(r_cfg_w);
    assign h_cl = clamp_side(r_cfg_h);

    assign bad_radius = (i_cmd.data.radius <= $signed(crp_pkg::FIX_W'(0)));
    assign bad_shape  = (i_cmd.data.shape_char != crp_pkg::SHAPE_FILLED) &&
                        (i_cmd.data.shape_char != crp_pkg::SHAPE_RIM);
    assign last_col   = (r_col == w_cl - SIDE_W'(1));
    assign last_row   = (r_row == h_cl - SIDE_W'(1));
    assign rm1        = r_radius - $signed(crp_pkg::ONE_FIX);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= crp_pkg::CFG_SIDE_W'(256);
            r_cfg_h  <= crp_pkg::CFG_SIDE_W'(256);
            r_cfg_bg <= 8'h20;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crp_pkg::CFG_WIDTH:  r_cfg_w  <= i_cfg_data;
                crp_pkg::CFG_HEIGHT: r_cfg_h  <= i_cfg_data;
                crp_pkg::CFG_BG:     r_cfg_bg <= i_cfg_data[crp_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // next state and strobes
    always_comb begin
        n_state  = r_state;
        accept   = 1'b0;
        clr_we   = 1'b0;
        rd_en    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            crp_pkg::ST_IDLE: begin
                accept = i_cmd.valid;
                if (i_cmd.valid) begin
                    case (i_cmd.data.kind)
                        crp_pkg::KIND_CLEAR: n_state = crp_pkg::ST_CLEAR;
                        crp_pkg::KIND_DRAW: begin
                            if (bad_radius || bad_shape) begin
                                n_state = crp_pkg::ST_RESULT;
                            end else begin
                                n_state = crp_pkg::ST_SETUP;
                            end
                        end
                        crp_pkg::KIND_READ:  n_state = crp_pkg::ST_READ;
                        default:             n_state = crp_pkg::ST_RESULT;
                    endcase
                end
            end
            crp_pkg::ST_CLEAR: begin
                clr_we = 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = crp_pkg::ST_RESULT;
                end
            end
            crp_pkg::ST_SETUP: n_state = crp_pkg::ST_DRAW;
            crp_pkg::ST_DRAW: begin
                issue = 1'b1;
                if (last_col && last_row) begin
                    n_state = crp_pkg::ST_DRAIN;
                end
            end
            crp_pkg::ST_DRAIN: begin
                if (!dist_busy) begin
                    n_state = crp_pkg::ST_RESULT;
                end
            end
            crp_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = crp_pkg::ST_RDATA;
            end
            crp_pkg::ST_RDATA: n_state = crp_pkg::ST_RESULT;
            crp_pkg::ST_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = crp_pkg::ST_IDLE;
                end
            end
            default: n_state = crp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and counters
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_circ.cx    <= i_cmd.data.center_x;
            r_circ.cy    <= i_cmd.data.center_y;
            r_circ.filled <= (i_cmd.data.shape_char == crp_pkg::SHAPE_FILLED);
            r_radius     <= i_cmd.data.radius;
            r_paint      <= i_cmd.data.paint_char;
            r_clr_addr   <= '0;
            r_rd_addr    <= AW'(i_cmd.data.row * MAX_SIDE + i_cmd.data.column);
            r_rd_ok      <= (SIDE_W'(i_cmd.data.row) < h_cl) &&
                            (SIDE_W'(i_cmd.data.column) < w_cl) &&
                            (int'(i_cmd.data.row) < MAX_SIDE) &&
                            (int'(i_cmd.data.column) < MAX_SIDE);
            r_res.pixel  <= '0;
            if (i_cmd.data.kind == crp_pkg::KIND_DRAW && bad_radius) begin
                r_res.status <= crp_pkg::STATUS_RADIUS;
            end else if (i_cmd.data.kind == crp_pkg::KIND_DRAW && bad_shape) begin
                r_res.status <= crp_pkg::STATUS_SHAPE;
            end else begin
                r_res.status <= crp_pkg::STATUS_OK;
            end
        end
        if (clr_we) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
        if (r_state == crp_pkg::ST_SETUP) begin
            r_circ.r2      <= crp_pkg::SQ_W'(crp_pkg::SQ_W'(r_radius) *
                                             crp_pkg::SQ_W'(r_radius));
            r_circ.rim2    <= crp_pkg::SQ_W'(crp_pkg::SQ_W'(rm1) * crp_pkg::SQ_W'(rm1));
            r_circ.rim_all <= (r_radius < $signed(crp_pkg::ONE_FIX));
            r_col          <= '0;
            r_row          <= '0;
            r_row_base     <= '0;
        end
        if (issue) begin
            if (last_col) begin
                r_col      <= '0;
                r_row      <= r_row + SIDE_W'(1);
                r_row_base <= r_row_base + AW'(MAX_SIDE);
            end else begin
                r_col <= r_col + SIDE_W'(1);
            end
        end
        if (r_state == crp_pkg::ST_RDATA) begin
            r_res.pixel <= r_rd_ok ? ram_rdata : '0;
        end
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    crp_dist #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_col   (r_col),
        .i_row   (r_row),
        .i_addr  (r_row_base + AW'(r_col)),
        .i_circ  (r_circ),
        .o_we    (dist_we),
        .o_waddr (dist_waddr),
        .o_busy  (dist_busy)
    );

    // clear and draw never overlap
    assign ram_we    = clr_we || dist_we;
    assign ram_waddr = clr_we ? r_clr_addr : dist_waddr;
    assign ram_wdata = clr_we ? r_cfg_bg : r_paint;

    crp_ram #(
        .WIDTH (crp_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready = (r_state == crp_pkg::ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

endmodule

`default_nettype wire

>>> design/crp_checker.sv
// crp_checker: port-level assertions for circle_raster_painter, bound to the top.
// Depends on crp_pkg for status codes.
`default_nettype none

module crp_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cmd_valid,
    input wire logic                            i_cmd_ready,
    input wire logic                            i_rsp_valid,
    input wire logic                            i_rsp_ready,
    input wire logic [crp_pkg::STATUS_W-1:0]    i_rsp_status,
    input wire logic [crp_pkg::CHAR_W-1:0]      i_rsp_pixel
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_pixel))
        else $error("result word changed while stalled");

    // one command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command accepted while busy");

    // a new result only comes out of a busy cycle
    a_rsp_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_cmd_ready))
        else $error("result appeared without work");

    // error results carry no pixel
    a_err_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != crp_pkg::STATUS_OK |-> i_rsp_pixel == '0)
        else $error("error result with nonzero pixel");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind circle_raster_painter crp_checker u_crp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.data.status),
    .i_rsp_pixel  (o_rsp.data.pixel)
);

`default_nettype wire

>>> dv/circle_raster_painter_tb.sv
// circle_raster_painter_tb: self-checking bench for the circle raster painter.
// Needs crp_pkg, crp_cmd_if, crp_rsp_if and the design; a scoreboard class mirrors
// the canvas, predicts each result word and checks the words in order.
`default_nettype none

module circle_raster_painter_tb;
    import crp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // unused kind, must answer zeros
    localparam int CANVAS_CELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int CELL_AW = $clog2(CANVAS_CELLS);

    class canvas_scoreboard;
        logic [CHAR_W-1:0] canvas_mem [CANVAS_CELLS];
        logic [CFG_SIDE_W-1:0] side_w;
        logic [CFG_SIDE_W-1:0] side_h;
        logic [CHAR_W-1:0] bg_char;
        t_rsp_word pending_results[$];
        int unsigned mismatches;

        function new();
            side_w = 9'd256;
            side_h = 9'd256;
            bg_char = 8'h20;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WIDTH:  side_w = val;
                CFG_HEIGHT: side_h = val;
                CFG_BG:     bg_char = val[CHAR_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_side(logic [CFG_SIDE_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
            return 32'(v);
        endfunction

        // distance test over every pixel in use; returns the draw status
        function logic [STATUS_W-1:0] paint_circle(t_cmd_word c, int unsigned w,
                                                   int unsigned h);
            longint cx, cy, r, r2, rim2, dx, dy, d2;
            bit rim_all;
            cx = longint'(c.center_x);
            cy = longint'(c.center_y);
            r  = longint'(c.radius);
            if (r <= 0) return STATUS_RADIUS;
            if (c.shape_char != SHAPE_FILLED && c.shape_char != SHAPE_RIM)
                return STATUS_SHAPE;
            r2 = r * r;
            rim_all = (r < longint'(ONE_FIX));
            rim2 = rim_all ? 0 : (r - longint'(ONE_FIX)) * (r - longint'(ONE_FIX));
            for (int unsigned y = 0; y < h; y++) begin
                dy = longint'(y) * longint'(ONE_FIX) - cy;
                for (int unsigned x = 0; x < w; x++) begin
                    dx = longint'(x) * longint'(ONE_FIX) - cx;
                    d2 = dx * dx + dy * dy;
                    if (d2 <= r2 && (c.shape_char == SHAPE_FILLED || rim_all || d2 > rim2))
                        canvas_mem[CELL_AW'(y * MAX_SIDE_DEF + x)] = c.paint_char;
                end
            end
            return STATUS_OK;
        endfunction

        function void note_command(t_cmd_word c);
            t_rsp_word due;
            int unsigned w, h;
            due = '0;
            w = clamp_side(side_w);
            h = clamp_side(side_h);
            case (c.kind)
                KIND_CLEAR: foreach (canvas_mem[i]) canvas_mem[i] = bg_char;
                KIND_DRAW:  due.status = paint_circle(c, w, h);
                KIND_READ: begin
                    if (c.row < h && c.column < w)
                        due.pixel = canvas_mem[{c.row, c.column}];
                end
                default: ;
            endcase
            pending_results.push_back(due);
        endfunction

        function void check_result(t_rsp_word got);
            t_rsp_word due;
            if (pending_results.size() == 0) begin
                $error("result word with none pending: status %0d pixel %0d",
                       got.status, got.pixel);
                mismatches++;
                return;
            end
            due = pending_results.pop_front();
            if (got.status !== due.status) begin
                $error("status: expected %0d, got %0d", due.status, got.status);
                mismatches++;
            end
            if (got.pixel !== due.pixel) begin
                $error("pixel: expected %0d, got %0d", due.pixel, got.pixel);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    crp_cmd_if cmd_ch();
    crp_rsp_if rsp_ch();

    canvas_scoreboard board = new();

    bit steady_flow = 1'b0;           // no gaps on either side while set
    int unsigned stall_request = 0;   // long receiver hold-off, in cycles

    circle_raster_painter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    function automatic logic signed [FIX_W-1:0] fix(int whole, int frac = 0);
        return FIX_W'(whole * 256 + frac);
    endfunction

    function automatic t_cmd_word noise_word();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return t_cmd_word'(raw[$bits(t_cmd_word)-1:0]);
    endfunction

    function automatic t_cmd_word make_clear();
        t_cmd_word c;
        c = noise_word();
        c.kind = KIND_CLEAR;
        return c;
    endfunction

    function automatic t_cmd_word make_draw(logic signed [FIX_W-1:0] cx,
                                            logic signed [FIX_W-1:0] cy,
                                            logic signed [FIX_W-1:0] r,
                                            logic [CHAR_W-1:0] shape,
                                            logic [CHAR_W-1:0] paint);
        t_cmd_word c;
        c = noise_word();
        c.kind = KIND_DRAW;
        c.center_x = cx;
        c.center_y = cy;
        c.radius = r;
        c.shape_char = shape;
        c.paint_char = paint;
        return c;
    endfunction

    function automatic t_cmd_word make_read(logic [COORD_W-1:0] row,
                                            logic [COORD_W-1:0] col);
        t_cmd_word c;
        c = noise_word();
        c.kind = KIND_READ;
        c.row = row;
        c.column = col;
        return c;
    endfunction

    // w, h are the sizes in use; most draws land on the canvas, reads mostly inside
    function automatic t_cmd_word random_word(int unsigned w, int unsigned h);
        t_cmd_word c;
        int unsigned roll, span;
        c = noise_word();
        roll = $urandom_range(0, 99);
        span = (w > h) ? w : h;
        if (roll < 6) begin
            c.kind = KIND_SPARE;
        end else if (roll < 52) begin
            c.kind = KIND_DRAW;
            if ($urandom_range(0, 99) < 85) begin
                c.shape_char = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_RIM;
                c.center_x = FIX_W'($urandom_range(0, (w + 4) * 256)) - FIX_W'(1024);
                c.center_y = FIX_W'($urandom_range(0, (h + 4) * 256)) - FIX_W'(1024);
                c.radius = FIX_W'($urandom_range(1, (span + 1) * 256));
            end else if ($urandom_range(0, 2) != 0) begin
                c.shape_char = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_RIM;
            end
        end else begin
            c.kind = KIND_READ;
            if ($urandom_range(0, 99) < 75) begin
                c.row = COORD_W'($urandom_range(0, (h > 255) ? 255 : h));
                c.column = COORD_W'($urandom_range(0, (w > 255) ? 255 : w));
            end
        end
        return c;
    endfunction

    task automatic send_word(t_cmd_word c, bit paced);
        int unsigned gap;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        board.note_command(c);
        @(negedge i_clk);
        if (paced) begin
            gap = pick_gap();
            if (gap != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_canvas(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                                  logic [CHAR_W-1:0] bg);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WIDTH;
        cfg_data <= w;
        @(negedge i_clk);
        cfg_idx  <= CFG_HEIGHT;
        cfg_data <= h;
        @(negedge i_clk);
        cfg_idx  <= CFG_BG;
        cfg_data <= {1'b0, bg};
        @(negedge i_clk);
        cfg_we <= 1'b0;
        board.set_register(CFG_WIDTH, w);
        board.set_register(CFG_HEIGHT, h);
        board.set_register(CFG_BG, {1'b0, bg});
        @(negedge i_clk);
    endtask

    // receiver: random ready, plus one long hold-off on request
    initial begin : rsp_driver
        int unsigned stall_left, gap_left;
        stall_left = 0;
        gap_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request != 0) begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.data);
    end

    initial begin : stimulus
        int unsigned w, h;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_WIDTH;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset sizes: whole canvas to the default background, corner reads
        send_word(make_clear(), 1);
        send_word(make_read(8'd0, 8'd0), 1);
        send_word(make_read(8'hFF, 8'hFF), 1);

        program_canvas(9'd12, 9'd10, ".");
        send_word(make_draw(fix(5, 128), fix(4, 128), fix(3), SHAPE_FILLED, "A"), 1);
        send_word(make_draw(fix(6), fix(5), fix(4, 64), SHAPE_RIM, "#"), 1);
        // rim with radius under one pixel paints the whole disk
        send_word(make_draw(fix(2), fix(2), fix(0, 200), SHAPE_RIM, "o"), 1);
        // unit radius rim: neighbors only, not the center
        send_word(make_draw(fix(9), fix(7), fix(1), SHAPE_RIM, "+"), 1);
        send_word(make_draw(fix(4), fix(4), fix(0), SHAPE_FILLED, "!"), 1);
        // radius check wins over a bad shape
        send_word(make_draw(fix(4), fix(4), 20'sh80000, "x", "!"), 1);
        send_word(make_draw(fix(4), fix(4), fix(3), "x", "!"), 1);
        send_word(make_draw(20'sh80000, 20'sh7FFFF, 20'sh7FFFF, SHAPE_FILLED, "Z"), 1);
        send_word(make_read(8'd2, 8'd2), 1);
        send_word(make_read(8'd7, 8'd9), 1);
        send_word(make_read(8'd7, 8'd10), 1);
        send_word(make_read(8'd5, 8'd6), 1);
        send_word(make_read(8'd1, 8'd6), 1);
        send_word(make_read(8'd4, 8'd5), 1);
        send_word(make_read(8'd9, 8'd11), 1);
        send_word(make_read(8'd10, 8'd3), 1);
        send_word(make_read(8'd3, 8'd12), 1);
        send_word(make_draw(fix(4), fix(4), fix(3), SHAPE_FILLED, 8'hFF) ^
                  t_cmd_word'({KIND_SPARE ^ KIND_DRAW, {($bits(t_cmd_word)-KIND_W){1'b0}}}),
                  1);
        send_word(make_draw(fix(6), fix(5), 20'sh7FFFF, SHAPE_FILLED, "@"), 1);
        send_word(make_read(8'd9, 8'd0), 1);

        // single pixel canvas
        program_canvas(9'd1, 9'd1, 8'hFF);
        for (int i = 0; i < 10; i++) send_word(random_word(1, 1), 1);

        // out-of-range sizes clamp to one column by the full height
        program_canvas(9'd0, 9'h1FF, 8'h00);
        send_word(make_clear(), 1);
        for (int i = 0; i < 12; i++) send_word(random_word(1, MAX_SIDE_DEF), 1);

        // full canvas, one large disk
        program_canvas(9'd256, 9'd256, 8'hFF);
        send_word(make_clear(), 1);
        send_word(make_draw(fix(128), fix(128), fix(100, 77), SHAPE_FILLED, "*"), 1);
        send_word(make_read(8'd128, 8'd128), 1);
        send_word(make_read(8'd128, 8'd28), 1);
        send_word(make_read(8'd128, 8'd27), 1);
        for (int i = 0; i < 5; i++)
            send_word(make_read(COORD_W'($urandom_range(0, 255)),
                                COORD_W'($urandom_range(0, 255))), 1);

        // small random canvases
        for (int p = 0; p < 4; p++) begin
            w = $urandom_range(2, 20);
            h = $urandom_range(2, 20);
            program_canvas(CFG_DATA_W'(w), CFG_DATA_W'(h), CHAR_W'($urandom_range(0, 255)));
            steady_flow = (p == 1);
            for (int i = 0; i < 16; i++) begin
                if (p == 2 && i == 6) begin
                    // hold the receiver off and keep offering words back to back;
                    // short reads make sure both result slots fill during the hold
                    stall_request = 1000;
                    for (int k = 0; k < 6; k++)
                        send_word(make_read(COORD_W'($urandom_range(0, h - 1)),
                                            COORD_W'($urandom_range(0, w - 1))), 0);
                end
                if (p == 3 && i == 8) wait_drained();
                send_word(random_word(w, h), 1);
            end
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (16) @(negedge i_clk);
        if (board.mismatches == 0) begin
            $display("circle_raster_painter_tb passed");
        end else begin
            $display("circle_raster_painter_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("circle_raster_painter_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
